### rtl/core/bounded_array_list_engine_macros.svh
// assertion macros of the list engine, used by the sequencer module
`ifndef BOUNDED_ARRAY_LIST_ENGINE_MACROS_SVH
`define BOUNDED_ARRAY_LIST_ENGINE_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define BALE_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bale assertion failed");

// next-cycle implication, sampled on clock, off during reset
`define BALE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bale assertion failed");

`endif

### rtl/core/bale_pkg.sv
// shared constants, types and helper functions of the list engine
package bale_pkg;

   localparam int CAPACITY   = 256;
   localparam int DATA_WIDTH = 32;

   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int FUNC_W     = 3;
   localparam int POS_W      = 8;
   localparam int VALUE_W    = 32;
   localparam int DATA_OUT_W = 32;
   localparam int TALLY_W    = 9;
   localparam int STATUS_W   = 2;
   localparam int LEN_W      = 9;
   localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef logic [DATA_WIDTH-1:0] word_type;
   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [CNT_W-1:0]      cnt_type;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_APPEND = 3'd0,
      FUNC_GET    = 3'd1,
      FUNC_SET    = 3'd2,
      FUNC_FIND   = 3'd3,
      FUNC_COUNT  = 3'd4,
      FUNC_DELETE = 3'd5,
      FUNC_CLEAR  = 3'd6
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   // command broadcast to every cell of the row
   typedef struct packed {
      logic     rotate;
      logic     shift_down;
      logic     write;
      idx_type  index;
      word_type wdata;
   } cell_cmd_type;

   function automatic word_type to_word(input logic [VALUE_W-1:0] v);
      return DATA_WIDTH'(v);
   endfunction

   function automatic logic [DATA_OUT_W-1:0] widen(input word_type w);
      return DATA_OUT_W'($signed(w));
   endfunction

   function automatic logic pos_out_of_range(input logic [POS_W-1:0] pos,
                                             input cnt_type count);
      return CMP_W'(pos) >= CMP_W'(count);
   endfunction

endpackage

### rtl/core/bale_if.sv
// transaction channels of the list engine: request and response
interface bale_req_if import bale_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [FUNC_W-1:0]         func;
   logic [POS_W-1:0]          position;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, func, position, value, input ready);
   modport sink   (input valid, func, position, value, output ready);
endinterface

interface bale_rsp_if import bale_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [DATA_OUT_W-1:0] data_out;
   logic [TALLY_W-1:0]           index_or_tally;
   logic                         found;
   logic [STATUS_W-1:0]          status;
   logic [LEN_W-1:0]             length;

   modport source (output valid, data_out, index_or_tally, found, status, length,
                   input ready);
   modport sink   (input valid, data_out, index_or_tally, found, status, length,
                   output ready);
endinterface

### rtl/core/bale_cell.sv
// one storage cell of the word row
module bale_cell import bale_pkg::*; (
   input  logic         clock,
   input  idx_type      cell_idx,
   input  cell_cmd_type cmd,
   input  word_type     nbr_word,
   output word_type     word_out
);

   word_type word_ff;
   word_type word_in;

   always_comb begin
      word_in = word_ff;
      if (cmd.rotate) begin
         word_in = nbr_word;
      end else if (cmd.shift_down && (cell_idx >= cmd.index)) begin
         word_in = nbr_word;
      end else if (cmd.write && (cell_idx == cmd.index)) begin
         word_in = cmd.wdata;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word_out = word_ff;

endmodule

### rtl/core/bale_ctrl.sv
// sequencer: decodes transactions, rotates the cell row, builds responses
`include "bounded_array_list_engine_macros.svh"

module bale_ctrl import bale_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   bale_req_if.sink       req_ch,
   bale_rsp_if.source     rsp_ch,
   input  word_type       head_word,
   output cell_cmd_type   cmd,
   output word_type       tail_word
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type  state_ff, state_in;
   cnt_type    count_ff, count_in;
   logic       rsp_valid_ff, rsp_valid_in;

   idx_type    step_ff, step_in;
   func_type   op_ff, op_in;
   idx_type    pos_ff, pos_in;
   word_type   val_ff, val_in;
   cnt_type    tally_ff, tally_in;
   logic       found_ff, found_in;
   word_type   data_ff, data_in;

   logic [DATA_OUT_W-1:0] rsp_data_ff, rsp_data_in;
   logic [TALLY_W-1:0]    rsp_tally_ff, rsp_tally_in;
   logic                  rsp_found_ff, rsp_found_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [LEN_W-1:0]      rsp_len_ff, rsp_len_in;

   logic     req_ready;
   logic     accept;
   logic     load_rsp;
   logic     match;
   func_type func;
   logic     append_grow;
   logic     scan_last;

   assign req_ready    = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = req_ready;
   assign accept       = req_ch.valid && req_ready;
   assign func         = func_type'(req_ch.func);
   assign match        = (CNT_W'(step_ff) < count_ff) && (head_word == val_ff);
   assign append_grow  = accept && (func == FUNC_APPEND) && (count_ff < CNT_W'(CAPACITY));
   assign scan_last    = (state_ff == ST_SCAN) && (step_ff == IDX_W'(CAPACITY - 1));

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      step_in       = step_ff;
      op_in         = op_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      tally_in      = tally_ff;
      found_in      = found_ff;
      data_in       = data_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_tally_in  = rsp_tally_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      rsp_len_in    = rsp_len_ff;
      load_rsp      = 1'b0;
      cmd           = '0;
      tail_word     = head_word;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_data_in   = '0;
               rsp_tally_in  = '0;
               rsp_found_in  = 1'b0;
               rsp_status_in = STATUS_OK;
               op_in         = func;
               pos_in        = IDX_W'(req_ch.position);
               val_in        = to_word(req_ch.value);
               step_in       = '0;
               tally_in      = '0;
               found_in      = 1'b0;
               data_in       = '0;
               unique case (func) inside
                  FUNC_APPEND: begin
                     load_rsp = 1'b1;
                     if (count_ff >= CNT_W'(CAPACITY)) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        cmd.write = 1'b1;
                        cmd.index = IDX_W'(count_ff);
                        cmd.wdata = to_word(req_ch.value);
                        count_in  = count_ff + 1'b1;
                     end
                  end
                  FUNC_GET, FUNC_SET, FUNC_DELETE: begin
                     if (pos_out_of_range(req_ch.position, count_ff)) begin
                        load_rsp      = 1'b1;
                        rsp_status_in = STATUS_RANGE;
                     end else if (func == FUNC_DELETE) begin
                        load_rsp       = 1'b1;
                        cmd.shift_down = 1'b1;
                        cmd.index      = IDX_W'(req_ch.position);
                        count_in       = count_ff - 1'b1;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  FUNC_FIND, FUNC_COUNT: begin
                     state_in = ST_SCAN;
                  end
                  FUNC_CLEAR: begin
                     load_rsp = 1'b1;
                     count_in = '0;
                  end
                  default: begin
                     load_rsp = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            cmd.rotate = 1'b1;
            case (op_ff)
               FUNC_FIND: begin
                  if (match && !found_ff) begin
                     found_in = 1'b1;
                     tally_in = CNT_W'(step_ff);
                  end
               end
               FUNC_COUNT: begin
                  if (match) begin
                     tally_in = tally_ff + 1'b1;
                  end
               end
               FUNC_GET, FUNC_SET: begin
                  if (step_ff == pos_ff) begin
                     data_in = head_word;
                     if (op_ff == FUNC_SET) begin
                        tail_word = val_ff;
                     end
                  end
               end
               default: begin
               end
            endcase
            step_in = step_ff + 1'b1;
            if (step_ff == IDX_W'(CAPACITY - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            load_rsp      = 1'b1;
            rsp_data_in   = widen(data_ff);
            rsp_tally_in  = TALLY_W'(tally_ff);
            rsp_found_in  = found_ff;
            rsp_status_in = STATUS_OK;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_len_in   = LEN_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff       <= step_in;
      op_ff         <= op_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      tally_ff      <= tally_in;
      found_ff      <= found_in;
      data_ff       <= data_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_tally_ff  <= rsp_tally_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_len_ff    <= rsp_len_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.data_out       = rsp_data_ff;
   assign rsp_ch.index_or_tally = rsp_tally_ff;
   assign rsp_ch.found          = rsp_found_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.length         = rsp_len_ff;

   `BALE_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CNT_W'(CAPACITY))
   `BALE_ASSERT_NEXT(a_append_grows, append_grow, count_ff == CNT_W'($past(count_ff) + 1'b1))
   `BALE_ASSERT_NEXT(a_scan_ends, scan_last, state_ff == ST_DONE)
   `BALE_ASSERT_NEXT(a_done_responds, state_ff == ST_DONE, rsp_valid_ff && (state_ff == ST_IDLE))

endmodule

### rtl/core/bounded_array_list_engine.sv
// top level of the list engine: sequencer and a ring of word cells
//
//   channel   direction  handshake      payload
//   req_ch    in         valid/ready    func, position, value
//   rsp_ch    out        valid/ready    data_out, index_or_tally, found, status, length
//
// append, delete, clear, rejected and unused codes: response registered in the cycle after acceptance
// get, set, find, count: ST_SCAN rotates the cell ring once through all CAPACITY cells,
// then ST_DONE loads the response register
// one transaction in work at a time; a new one is taken when the output register frees
// reset clears the length and handshake state; stored words are not cleared
module bounded_array_list_engine import bale_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   bale_req_if.sink   req_ch,
   bale_rsp_if.source rsp_ch
);

   cell_cmd_type cmd;
   word_type     tail_word;
   word_type     row [CAPACITY];

   bale_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .head_word (row[0]),
      .cmd       (cmd),
      .tail_word (tail_word)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      word_type nbr_word;
      if (i == CAPACITY - 1) begin : g_tail
         assign nbr_word = tail_word;
      end else begin : g_body
         assign nbr_word = row[i+1];
      end
      bale_cell u_cell (
         .clock    (clock),
         .cell_idx (IDX_W'(i)),
         .cmd      (cmd),
         .nbr_word (nbr_word),
         .word_out (row[i])
      );
   end

endmodule
